@@ hdl/ofsl_pkg.sv @@
`default_nettype none

package ofsl_pkg;

   localparam int unsigned WORD_W = 16;

   // Section header marks
   localparam logic [WORD_W-1:0] HDR_CODE = 16'hCADE;
   localparam logic [WORD_W-1:0] HDR_DATA = 16'hDADA;
   localparam logic [WORD_W-1:0] HDR_SYMB = 16'hC3B7;
   localparam logic [WORD_W-1:0] HDR_FILE = 16'hF17E;
   localparam logic [WORD_W-1:0] HDR_LINE = 16'h715E;

   // Words skipped after a line-number header
   localparam logic [WORD_W-1:0] LINE_SKIP = 16'd3;

   // Command passed from the parser to the writer
   typedef struct packed {
      logic              is_addr;   // 1: set running address, 0: emit a write
      logic              is_data;   // write came from a data section
      logic [WORD_W-1:0] value;     // address or payload word
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/ofsl_parser.sv @@
`default_nettype none

module ofsl_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [ofsl_pkg::WORD_W-1:0] word,
   input  wire logic                        start_of_file,
   output ofsl_pkg::cmd_type                cmd,
   output logic                             cmd_push
);

   typedef enum logic [2:0] {
      PH_SEEK  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_COUNT = 3'd2,
      PH_LOAD  = 3'd3,
      PH_SKIP  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CODE = 3'd0,
      KIND_DATA = 3'd1,
      KIND_SYMB = 3'd2,
      KIND_FILE = 3'd3,
      KIND_LINE = 3'd4
   } kind_type;

   phase_type                    phase_ff, phase_in, phase_eff;
   kind_type                     kind_ff, kind_in;
   logic [ofsl_pkg::WORD_W-1:0]  remaining_ff, remaining_in;
   logic [ofsl_pkg::WORD_W-1:0]  remaining_dec;
   logic [ofsl_pkg::WORD_W-1:0]  skip_count;
   logic                         kind_loads;

   // Restart header search on a start-of-file word
   assign phase_eff     = start_of_file ? PH_SEEK : phase_ff;
   assign remaining_dec = remaining_ff - 1'b1;
   // Symbol and file-name payload: (count+1)/2 words, formed in 17 bits
   assign skip_count    = ofsl_pkg::WORD_W'(({1'b0, word} + 17'd1) >> 1);
   assign kind_loads    = kind_ff inside {KIND_CODE, KIND_DATA};

   // Classify the word and pick the next parse state
   always_comb begin
      phase_in     = phase_eff;
      kind_in      = kind_ff;
      remaining_in = remaining_ff;
      cmd_push     = 1'b0;
      cmd.is_addr  = 1'b0;
      cmd.is_data  = (kind_ff == KIND_DATA);
      cmd.value    = word;
      case (phase_eff)
         PH_ADDR: begin
            cmd.is_addr = 1'b1;
            cmd_push    = kind_loads;
            phase_in    = PH_COUNT;
         end
         PH_COUNT: begin
            if (kind_loads) begin
               remaining_in = word;
               phase_in     = (word == '0) ? PH_SEEK : PH_LOAD;
            end else begin
               remaining_in = skip_count;
               phase_in     = (skip_count == '0) ? PH_SEEK : PH_SKIP;
            end
         end
         PH_LOAD: begin
            cmd_push     = 1'b1;
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_SEEK;
            end
         end
         PH_SKIP: begin
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_SEEK;
            end
         end
         default: begin
            phase_in = PH_SEEK;
            case (word)
               ofsl_pkg::HDR_CODE: begin
                  kind_in  = KIND_CODE;
                  phase_in = PH_ADDR;
               end
               ofsl_pkg::HDR_DATA: begin
                  kind_in  = KIND_DATA;
                  phase_in = PH_ADDR;
               end
               ofsl_pkg::HDR_SYMB: begin
                  kind_in  = KIND_SYMB;
                  phase_in = PH_ADDR;
               end
               ofsl_pkg::HDR_FILE: begin
                  kind_in  = KIND_FILE;
                  phase_in = PH_COUNT;
               end
               ofsl_pkg::HDR_LINE: begin
                  kind_in      = KIND_LINE;
                  remaining_in = ofsl_pkg::LINE_SKIP;
                  phase_in     = PH_SKIP;
               end
               default: begin
                  phase_in = PH_SEEK;
               end
            endcase
         end
      endcase
   end

   // Hold parse state; advance only on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEEK;
         kind_ff      <= KIND_CODE;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         remaining_ff <= remaining_in;
      end
   end

   // Payload loading and skipping always have words left to take
   a_load_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LOAD || phase_ff == PH_SKIP) |-> (remaining_ff != '0))
      else $error("parser in load or skip with no words left");

   // A write command only leaves while loading a code or data section
   a_push_kind: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && !cmd.is_addr) |-> (phase_eff == PH_LOAD && kind_loads))
      else $error("write command outside a code or data payload");

   // The last payload word returns the parser to header search
   a_load_end: assert property (@(posedge clock) disable iff (reset)
      (accept && !start_of_file && phase_ff == PH_LOAD && remaining_ff == 16'd1)
      |=> (phase_ff == PH_SEEK))
      else $error("parser did not return to header search");

endmodule

`default_nettype wire

@@ hdl/ofsl_queue.sv @@
`default_nettype none

module ofsl_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ofsl_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output ofsl_pkg::cmd_type      head_cmd,
   output logic                   not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ofsl_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Hold pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

@@ hdl/ofsl_writer.sv @@
`default_nettype none

module ofsl_writer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ofsl_pkg::cmd_type           cmd,
   input  wire logic                        cmd_valid,
   output logic                             cmd_pop,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [ofsl_pkg::WORD_W-1:0]      rsp_write_address,
   output logic [ofsl_pkg::WORD_W-1:0]      rsp_write_data,
   output logic                             rsp_section_is_data
);

   logic [ofsl_pkg::WORD_W-1:0] addr_ff, addr_in;
   logic                        out_valid_ff, out_valid_in;
   logic [ofsl_pkg::WORD_W-1:0] out_addr_ff, out_data_ff;
   logic                        out_is_data_ff;
   logic                        out_free;
   logic                        take_write;

   // Output slot frees up when empty or when its request leaves this cycle
   assign out_free   = !out_valid_ff || rsp_pop;
   assign cmd_pop    = cmd_valid && (cmd.is_addr || out_free);
   assign take_write = cmd_pop && !cmd.is_addr;

   // Load or advance the running address, wrapping at 16 bits
   always_comb begin
      addr_in = addr_ff;
      if (cmd_pop && cmd.is_addr) begin
         addr_in = cmd.value;
      end else if (take_write) begin
         addr_in = addr_ff + 1'b1;
      end
      out_valid_in = take_write ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the write request
   always_ff @(posedge clock) begin
      if (take_write) begin
         out_addr_ff    <= addr_ff;
         out_data_ff    <= cmd.value;
         out_is_data_ff <= cmd.is_data;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_write_address   = out_addr_ff;
   assign rsp_write_data      = out_data_ff;
   assign rsp_section_is_data = out_is_data_ff;

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      take_write |=> !rsp_empty)
      else $error("taken write not presented");

   a_addr_step: assert property (@(posedge clock) disable iff (reset)
      take_write |=> (addr_ff == $past(addr_ff) + 1'b1))
      else $error("running address did not advance");

   a_addr_load: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.is_addr) |=> (addr_ff == $past(cmd.value)))
      else $error("running address not loaded");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      take_write |-> (rsp_empty || rsp_pop))
      else $error("write request overwritten");

endmodule

`default_nettype wire

@@ hdl/object_file_section_loader.sv @@
// Object file section loader.
// Request side is a queue input: present req_word and req_start_of_file with
// req_push; the word is taken at a clock edge where req_push is high and
// req_full is low. Result side is a queue output: while rsp_empty is low the
// oldest memory write sits on rsp_write_address, rsp_write_data and
// rsp_section_is_data, and it leaves at an edge where rsp_pop is high.
// One word is taken per cycle while req_full is low. The parser classifies
// each word in the cycle it is taken and queues a command; with the result
// side free, the writer turns a payload word into a write that shows on the
// result ports after passing the command queue, then the result register.
// Headers, counts, addresses and skipped words give no write.
// When the receiver stalls, writes pile up in the command queue
// (QUEUE_DEPTH entries) and the result register; req_full rises once the
// queue is full and drops as soon as a command moves on.
// Reset (synchronous, active high) returns the parser to header search,
// empties the queue and the result register and clears the running address.
`default_nettype none

module object_file_section_loader #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [15:0] req_word,
   input  wire logic        req_start_of_file,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [15:0]      rsp_write_address,
   output logic [15:0]      rsp_write_data,
   output logic             rsp_section_is_data
);

   ofsl_pkg::cmd_type parse_cmd, head_cmd;
   logic              parse_push;
   logic              accept;
   logic              queue_full, queue_not_empty, queue_pop;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // Front: classify words
   ofsl_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .word          (req_word),
      .start_of_file (req_start_of_file),
      .cmd           (parse_cmd),
      .cmd_push      (parse_push)
   );

   // Decouple front and back
   ofsl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && parse_push),
      .push_cmd  (parse_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_cmd  (head_cmd),
      .not_empty (queue_not_empty)
   );

   // Back: track the address and present writes
   ofsl_writer u_writer (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (head_cmd),
      .cmd_valid           (queue_not_empty),
      .cmd_pop             (queue_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_data      (rsp_write_data),
      .rsp_section_is_data (rsp_section_is_data)
   );

endmodule

`default_nettype wire

@@ tb/section_write_predictor.sv @@
`timescale 1ns / 1ps

// Watch both queues of the loader, predict the memory writes from the words
// it takes, and compare every write that leaves against the oldest one due.
module section_write_predictor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [15:0] req_word,
   input  logic        req_start_of_file,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [15:0] rsp_write_address,
   input  logic [15:0] rsp_write_data,
   input  logic        rsp_section_is_data,
   output int          fail_count,
   output int          pending,
   output int          words_seen,
   output int          writes_seen
);

   typedef enum logic [2:0] {
      SEEK_HEADER,
      READ_ADDRESS,
      READ_COUNT,
      LOAD_PAYLOAD,
      SKIP_WORDS
   } parse_phase_type;

   typedef enum logic [2:0] {
      SEC_CODE,
      SEC_DATA,
      SEC_SYMBOL,
      SEC_FILENAME,
      SEC_LINENUM
   } section_type;

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] data;
      logic        is_data;
   } mem_write_type;

   parse_phase_type phase;
   section_type     kind;
   logic [15:0]     run_address;
   logic [15:0]     words_left;
   mem_write_type   due_writes [$];

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("%0t MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // Advance the parser by one word and return the write it causes, if any
   task automatic parse_word(input logic [15:0] w, input logic sof,
                             output bit emits, output mem_write_type wr);
      logic [16:0] half;
      emits = 1'b0;
      wr = '0;
      half = ({1'b0, w} + 17'd1) >> 1;
      if (sof) begin
         phase = SEEK_HEADER;
      end
      case (phase)
         READ_ADDRESS: begin
            run_address = w;
            phase = READ_COUNT;
         end
         READ_COUNT: begin
            if (kind == SEC_CODE || kind == SEC_DATA) begin
               if (w == 16'd0) begin
                  phase = SEEK_HEADER;
               end else begin
                  words_left = w;
                  phase = LOAD_PAYLOAD;
               end
            end else if (half == 17'd0) begin
               phase = SEEK_HEADER;
            end else begin
               words_left = half[15:0];
               phase = SKIP_WORDS;
            end
         end
         LOAD_PAYLOAD: begin
            emits = 1'b1;
            wr.address = run_address;
            wr.data = w;
            wr.is_data = (kind == SEC_DATA);
            run_address = run_address + 16'd1;
            words_left = words_left - 16'd1;
            if (words_left == 16'd0) begin
               phase = SEEK_HEADER;
            end
         end
         SKIP_WORDS: begin
            words_left = words_left - 16'd1;
            if (words_left == 16'd0) begin
               phase = SEEK_HEADER;
            end
         end
         default: begin
            phase = SEEK_HEADER;
            case (w)
               ofsl_pkg::HDR_CODE: begin
                  kind = SEC_CODE;
                  phase = READ_ADDRESS;
               end
               ofsl_pkg::HDR_DATA: begin
                  kind = SEC_DATA;
                  phase = READ_ADDRESS;
               end
               ofsl_pkg::HDR_SYMB: begin
                  kind = SEC_SYMBOL;
                  phase = READ_ADDRESS;
               end
               ofsl_pkg::HDR_FILE: begin
                  kind = SEC_FILENAME;
                  phase = READ_COUNT;
               end
               ofsl_pkg::HDR_LINE: begin
                  kind = SEC_LINENUM;
                  words_left = ofsl_pkg::LINE_SKIP;
                  phase = SKIP_WORDS;
               end
               default: ;
            endcase
         end
      endcase
   endtask

   // Compare leaving writes first, then predict from the word taken
   always @(posedge clock) begin
      mem_write_type got;
      mem_write_type want;
      mem_write_type pred;
      bit            emits;
      if (reset) begin
         phase = SEEK_HEADER;
         kind = SEC_CODE;
         run_address = 16'd0;
         words_left = 16'd0;
         due_writes.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_write_address, rsp_write_data, rsp_section_is_data};
            writes_seen++;
            if (due_writes.size() == 0) begin
               report_mismatch($sformatf("write %h <= %h (data=%b) with none due",
                                         got.address, got.data, got.is_data));
            end else begin
               want = due_writes.pop_front();
               if (got.address !== want.address)
                  report_mismatch($sformatf("write address %h, wanted %h",
                                            got.address, want.address));
               if (got.data !== want.data)
                  report_mismatch($sformatf("write data %h at %h, wanted %h",
                                            got.data, want.address, want.data));
               if (got.is_data !== want.is_data)
                  report_mismatch($sformatf("section_is_data %b at %h, wanted %b",
                                            got.is_data, want.address, want.is_data));
            end
         end
         if (req_push && !req_full) begin
            words_seen++;
            parse_word(req_word, req_start_of_file, emits, pred);
            if (emits) begin
               due_writes.push_back(pred);
            end
         end
      end
      pending = due_writes.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_WORDS = 450;
   localparam int CALM_WORDS = 80;
   localparam int STALL_LIMIT = 500;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [15:0] req_word = 16'd0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_write_address;
   logic [15:0] rsp_write_data;
   logic        rsp_section_is_data;

   int fail_count;
   int pending;
   int words_seen;
   int writes_seen;

   bit idle_on = 1'b1;
   int sent_words;
   int sof_count;
   int section_count;
   int stall_left;
   int quiet_cycles;

   object_file_section_loader dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_word            (req_word),
      .req_start_of_file   (req_start_of_file),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_data      (rsp_write_data),
      .rsp_section_is_data (rsp_section_is_data)
   );

   section_write_predictor write_predict (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_word            (req_word),
      .req_start_of_file   (req_start_of_file),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_data      (rsp_write_data),
      .rsp_section_is_data (rsp_section_is_data),
      .fail_count          (fail_count),
      .pending             (pending),
      .words_seen          (words_seen),
      .writes_seen         (writes_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side in short random bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_pop <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // End the run when neither queue moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d writes still due",
                  STALL_LIMIT, pending);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request after a falling edge and hold it until taken
   task automatic send_word(input logic [15:0] w, input logic sof);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      req_start_of_file <= sof;
      do begin
         @(posedge clock);
      end while (req_full);
      sent_words++;
      if (sof) sof_count++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_mark();
      case ($urandom_range(0, 4))
         0: return ofsl_pkg::HDR_CODE;
         1: return ofsl_pkg::HDR_DATA;
         2: return ofsl_pkg::HDR_SYMB;
         3: return ofsl_pkg::HDR_FILE;
         default: return ofsl_pkg::HDR_LINE;
      endcase
   endfunction

   // Mostly random words, with header marks and extremes mixed in
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return pick_mark();
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic pick_sof();
      return $urandom_range(0, 39) == 0;
   endfunction

   initial begin
      logic [15:0] hdr;
      logic [15:0] count;
      int          rand_base;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: unknown words while seeking
      send_word(16'h0000, 1'b1);
      send_word(16'hFFFF, 1'b0);
      // Code section running across the address wrap
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(16'hFFFE, 1'b0);
      send_word(16'h0003, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'hA5A5, 1'b0);
      // Data section with zero count, then one with a single word
      send_word(ofsl_pkg::HDR_DATA, 1'b0);
      send_word(16'h1234, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(ofsl_pkg::HDR_DATA, 1'b0);
      send_word(16'h0010, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(16'h5A5A, 1'b0);
      // Symbol section skipping two header marks, then one with zero count
      send_word(ofsl_pkg::HDR_SYMB, 1'b0);
      send_word(16'h4000, 1'b0);
      send_word(16'h0003, 1'b0);
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(ofsl_pkg::HDR_DATA, 1'b0);
      send_word(ofsl_pkg::HDR_SYMB, 1'b0);
      send_word(16'h4000, 1'b0);
      send_word(16'h0000, 1'b0);
      // File-name sections with count one and zero
      send_word(ofsl_pkg::HDR_FILE, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(ofsl_pkg::HDR_LINE, 1'b0);
      send_word(ofsl_pkg::HDR_FILE, 1'b0);
      send_word(16'h0000, 1'b0);
      // Line-number section swallows three marks
      send_word(ofsl_pkg::HDR_LINE, 1'b0);
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(ofsl_pkg::HDR_DATA, 1'b0);
      send_word(ofsl_pkg::HDR_FILE, 1'b0);
      // Start flag mid-payload restarts on a data header
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(16'h0100, 1'b0);
      send_word(16'h0004, 1'b0);
      send_word(16'h1111, 1'b0);
      send_word(ofsl_pkg::HDR_DATA, 1'b1);
      send_word(16'h0200, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(16'h2222, 1'b0);
      // Start flag on a plain word abandons a section header
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(16'h1234, 1'b1);

      // Largest file-name count, cut short by a start flag on a code header
      send_word(ofsl_pkg::HDR_FILE, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(ofsl_pkg::HDR_CODE, 1'b0);
      send_word(ofsl_pkg::HDR_DATA, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(16'h9999, 1'b0);
      send_word(ofsl_pkg::HDR_CODE, 1'b1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0002, 1'b0);
      send_word(16'h1357, 1'b0);
      send_word(16'h2468, 1'b0);

      // Random: mostly well-formed sections with random content, some noise
      rand_base = sent_words;
      while (sent_words - rand_base < RANDOM_WORDS) begin
         if (sent_words - rand_base >= RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            send_word(pick_word(), pick_sof());
            continue;
         end
         section_count++;
         hdr = pick_mark();
         send_word(hdr, $urandom_range(0, 3) == 0);
         case (hdr)
            ofsl_pkg::HDR_CODE, ofsl_pkg::HDR_DATA: begin
               send_word($urandom_range(0, 3) == 0 ? 16'hFFFF - 16'($urandom_range(0, 3))
                                                   : 16'($urandom), pick_sof());
               count = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
               send_word(count, pick_sof());
               repeat (count) send_word(pick_word(), pick_sof());
            end
            ofsl_pkg::HDR_SYMB: begin
               send_word(16'($urandom), pick_sof());
               count = 16'($urandom_range(0, 9));
               send_word(count, pick_sof());
               repeat ((count + 16'd1) >> 1) send_word(pick_word(), pick_sof());
            end
            ofsl_pkg::HDR_FILE: begin
               count = 16'($urandom_range(0, 9));
               send_word(count, pick_sof());
               repeat ((count + 16'd1) >> 1) send_word(pick_word(), pick_sof());
            end
            default: begin
               repeat (ofsl_pkg::LINE_SKIP) send_word(pick_word(), pick_sof());
            end
         endcase
      end
      idle_on = 1'b0;
      req_push <= 1'b0;

      // Drain the writes still due, then watch for strays
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d object file words (%0d random sections, %0d start-of-file flags).",
               words_seen, section_count, sof_count);
      $display("Checked %0d memory writes against the prediction; %0d mismatches.",
               writes_seen, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
